// File: hw/rtl/mhu_pkg.sv
// ----------------------------------------------------------------------------
// mhu_pkg: shared types and constants for the MIME header unfolder
// Character codes, the scan mode encoding and the op queue entry format.
// ----------------------------------------------------------------------------
package mhu_pkg;

  localparam int unsigned MaxLenDefault = 1024;
  localparam int unsigned QDepth        = 4;

  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChSemi  = 8'h3B;
  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChEqual = 8'h3D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChQuote = 8'h22;

  typedef enum logic [5:0] {
    MODE_NORMAL = 6'b000001,
    MODE_QUOTED = 6'b000010,
    MODE_LF     = 6'b000100,
    MODE_CR     = 6'b001000,
    MODE_CRLF   = 6'b010000,
    MODE_STOP   = 6'b100000
  } scan_mode_e;

  typedef enum logic [1:0] {
    OP_BYTE       = 2'd0,
    OP_SPACE_BYTE = 2'd1,
    OP_DONE       = 2'd2
  } op_kind_e;

  typedef struct packed {
    op_kind_e   kind;
    logic [7:0] data;
    logic       is_colon;   // separator colon outside quotes
  } op_t;

endpackage

// File: hw/rtl/mhu_front.sv
// ----------------------------------------------------------------------------
// mhu_front: input classifier
// Tracks quoting, folding and white space; turns each byte that yields output, and the end mark, into an op.
// ----------------------------------------------------------------------------
module mhu_front import mhu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       end_mark_i,
  input  logic       q_full_i,
  output logic       push_o,
  output op_t        push_op_o
);

  scan_mode_e mode_q, mode_d;
  logic       space_q, space_d;
  logic       sep_q, sep_d;
  logic       emit;
  logic       accept;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign push_o     = accept && emit;

  always_comb begin
    logic is_lws;
    logic is_sep;
    is_lws = (in_byte_i == ChSpace) || (in_byte_i == ChTab);
    is_sep = (in_byte_i == ChColon) || (in_byte_i == ChSemi) ||
             (in_byte_i == ChComma) || (in_byte_i == ChEqual);
    mode_d    = mode_q;
    space_d   = space_q;
    sep_d     = sep_q;
    emit      = 1'b0;
    push_op_o = '{kind: OP_BYTE, data: in_byte_i, is_colon: 1'b0};

    if (end_mark_i) begin
      emit           = 1'b1;
      push_op_o.kind = OP_DONE;
      mode_d         = MODE_NORMAL;
      space_d        = 1'b0;
      sep_d          = 1'b0;
    end else begin
      case (mode_q)
        MODE_NORMAL: begin
          if (is_sep) begin
            space_d            = 1'b0;
            emit               = 1'b1;
            push_op_o.is_colon = (in_byte_i == ChColon);
            sep_d              = 1'b1;
          end else if (is_lws) begin
            space_d = 1'b1;
          end else if (in_byte_i == ChLf) begin
            space_d = 1'b0;
            mode_d  = MODE_LF;
          end else if (in_byte_i == ChCr) begin
            space_d = 1'b0;
            mode_d  = MODE_CR;
          end else if (in_byte_i == ChQuote) begin
            // after_separator deliberately kept across the quoted string
            space_d = 1'b0;
            emit    = 1'b1;
            mode_d  = MODE_QUOTED;
          end else begin
            emit = 1'b1;
            if (sep_q) begin
              sep_d = 1'b0;
            end else if (space_q) begin
              push_op_o.kind = OP_SPACE_BYTE;
            end
            space_d = 1'b0;
          end
        end
        MODE_QUOTED: begin
          emit = 1'b1;
          if (in_byte_i == ChQuote) mode_d = MODE_NORMAL;
        end
        MODE_LF, MODE_CRLF: begin
          if (is_lws) begin
            space_d = 1'b1;
            mode_d  = MODE_NORMAL;
          end else begin
            mode_d = MODE_STOP;
          end
        end
        MODE_CR: begin
          if (in_byte_i == ChLf) begin
            mode_d = MODE_CRLF;
          end else if (is_lws) begin
            space_d = 1'b1;
            mode_d  = MODE_NORMAL;
          end else begin
            mode_d = MODE_STOP;
          end
        end
        default: ;  // stopped: ignore until end mark
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_NORMAL;
      space_q <= 1'b0;
      sep_q   <= 1'b0;
    end else if (accept) begin
      mode_q  <= mode_d;
      space_q <= space_d;
      sep_q   <= sep_d;
    end
  end

endmodule

// File: hw/rtl/mhu_queue.sv
// ----------------------------------------------------------------------------
// mhu_queue: op queue
// Small FIFO that decouples the classifier from the output sequencer.
// ----------------------------------------------------------------------------
module mhu_queue import mhu_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  op_t  push_op_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output op_t  head_o
);

  localparam int unsigned PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned CntW = $clog2(QDepth + 1);

  op_t             mem_q [QDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(QDepth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_op_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == PtrW'(QDepth - 1)) ? '0 : wr_q + 1'b1;
      if (do_pop)  rd_q <= (rd_q == PtrW'(QDepth - 1)) ? '0 : rd_q + 1'b1;
      if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

// File: hw/rtl/mhu_back.sv
// ----------------------------------------------------------------------------
// mhu_back: output sequencer
// Expands ops into result items, counts output bytes, tracks the first colon.
// ----------------------------------------------------------------------------
module mhu_back import mhu_pkg::*; #(
  parameter int unsigned MAX_LEN = MaxLenDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  input  op_t         q_head_i,
  output logic        q_pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        byte_valid_o,
  output logic        done_res_o,
  output logic        colon_found_o,
  output logic [9:0]  colon_pos_o,
  output logic        run_last_o
);

  localparam int unsigned CntW = $clog2(MAX_LEN);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_LEN - 1);

  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [CntW-1:0]    cpos_q, cpos_d;
  logic               cseen_q, cseen_d;
  logic               phase_q, phase_d;   // space half of a space+byte op sent
  logic               valid_q;
  logic               load;
  logic [CntW+9:0]    pos_ext;

  logic [7:0] byte_d;
  logic       bval_d, done_d, cfound_d, last_d;
  logic [9:0] cpos10_d;

  assign load        = q_valid_i && (!valid_q || out_ready_i);
  assign out_valid_o = valid_q;
  assign pos_ext     = {10'd0, cpos_q};

  always_comb begin
    logic bump;
    cnt_d    = cnt_q;
    cpos_d   = cpos_q;
    cseen_d  = cseen_q;
    phase_d  = phase_q;
    q_pop_o  = 1'b0;
    bump     = 1'b0;
    byte_d   = q_head_i.data;
    bval_d   = 1'b1;
    done_d   = 1'b0;
    cfound_d = 1'b0;
    cpos10_d = '0;
    last_d   = 1'b1;

    case (q_head_i.kind)
      OP_DONE: begin
        byte_d   = '0;
        bval_d   = 1'b0;
        done_d   = 1'b1;
        cfound_d = cseen_q;
        cpos10_d = cseen_q ? pos_ext[9:0] : '0;
        if (load) begin
          q_pop_o = 1'b1;
          cnt_d   = '0;
          cpos_d  = '0;
          cseen_d = 1'b0;
          phase_d = 1'b0;
        end
      end
      OP_SPACE_BYTE: begin
        bump = 1'b1;
        if (!phase_q) begin
          byte_d = ChSpace;
          last_d = 1'b0;
          if (load) phase_d = 1'b1;
        end else if (load) begin
          q_pop_o = 1'b1;
          phase_d = 1'b0;
        end
      end
      default: begin
        bump = 1'b1;
        if (load) q_pop_o = 1'b1;
        if (load && q_head_i.is_colon && !cseen_q) begin
          cseen_d = 1'b1;
          cpos_d  = cnt_q;
        end
      end
    endcase

    if (load && bump && cnt_q != MaxCnt) cnt_d = cnt_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cnt_q   <= '0;
      cpos_q  <= '0;
      cseen_q <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      if (load)             valid_q <= 1'b1;
      else if (out_ready_i) valid_q <= 1'b0;
      cnt_q   <= cnt_d;
      cpos_q  <= cpos_d;
      cseen_q <= cseen_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_o    <= byte_d;
      byte_valid_o  <= bval_d;
      done_res_o    <= done_d;
      colon_found_o <= cfound_d;
      colon_pos_o   <= cpos10_d;
      run_last_o    <= last_d;
    end
  end

endmodule

// File: hw/rtl/mime_header_unfold_compact_top.sv
// Path: an accepted input item becomes an op in the op queue, and the output sequencer
// loads its first result item from there. Throughput: 1 input item per cycle while the
// op queue is not full; an item that inserts a space before its byte holds the output
// sequencer for both of its results, set by its single output port. Results per item:
// 0, 1 or 2. A 4-entry op queue buffers the difference. Reset (rst_ni low, asynchronous)
// empties the queue and returns all state to the start of a header.
// ----------------------------------------------------------------------------
// mime_header_unfold_compact_top: MIME header unfolder and compactor
// Unfolds folded lines, compacts white space and reports the first colon.
// ----------------------------------------------------------------------------
module mime_header_unfold_compact_top import mhu_pkg::*; #(
  parameter int unsigned MAX_LEN = MaxLenDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,   // end_mark
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] out_byte, [8] colon_found,
                                      // [18:9] colon_pos, [23:19] zero
  output logic [1:0]  m_axis_tuser,   // [0] byte_valid, [1] done_res
  output logic        m_axis_tlast    // run_last
);

  logic       q_push, q_full, q_pop, q_valid;
  op_t        q_in, q_head;
  logic [7:0] out_byte;
  logic       byte_valid, done_res, colon_found;
  logic [9:0] colon_pos;

  mhu_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_byte_i  (s_axis_tdata),
    .end_mark_i (s_axis_tlast),
    .q_full_i   (q_full),
    .push_o     (q_push),
    .push_op_o  (q_in)
  );

  mhu_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (q_push),
    .push_op_i (q_in),
    .full_o    (q_full),
    .pop_i     (q_pop),
    .valid_o   (q_valid),
    .head_o    (q_head)
  );

  mhu_back #(.MAX_LEN(MAX_LEN)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_head_i      (q_head),
    .q_pop_o       (q_pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_byte_o    (out_byte),
    .byte_valid_o  (byte_valid),
    .done_res_o    (done_res),
    .colon_found_o (colon_found),
    .colon_pos_o   (colon_pos),
    .run_last_o    (m_axis_tlast)
  );

  assign m_axis_tdata = {5'd0, colon_pos, colon_found, out_byte};
  assign m_axis_tuser = {done_res, byte_valid};

  // a result is either a character or a done marker, never both
  a_kind_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> $onehot(m_axis_tuser))
    else $error("result kind not one-hot");

  // character results carry no colon report
  a_char_no_colon: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[18:8] == 11'd0))
    else $error("colon fields set on character result");

  // done result always closes its run
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[1]) |-> m_axis_tlast)
    else $error("done result without run_last");

  // classifier never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("op queue overflow");

endmodule

// File: tb/mime_header_unfold_compact_top_tb.sv
// ----------------------------------------------------------------------------
// mime_header_unfold_compact_top_tb: testbench for the MIME header unfolder
// Feeds header bytes with random valid/ready idling and checks every output
// item against a cycle-free model of the unfold and compaction rules.
// ----------------------------------------------------------------------------
module mime_header_unfold_compact_top_tb;
  import mhu_pkg::*;

  localparam int unsigned MaxLen   = MaxLenDefault;
  localparam int unsigned IdlePct  = 21;
  localparam int unsigned RandGoal = 950;
  localparam int unsigned WdLimit  = 2000;
  localparam int unsigned QuietLo  = 300;
  localparam int unsigned QuietHi  = 480;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } hdr_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       done_res;
    logic       colon_found;
    logic [9:0] colon_pos;
    logic       run_last;
  } out_item_t;

  // Predicts the compacted stream and holds the output items still owed.
  class unfold_scoreboard;
    scan_mode_e  mode;
    bit          space_due;
    bit          sep_last;
    bit          colon_seen;
    logic [9:0]  colon_at;
    int unsigned out_cnt;
    int unsigned max_len;
    int unsigned err_cnt;
    out_item_t   pending_out[$];

    function new(int unsigned len);
      max_len = len;
      err_cnt = 0;
      restart();
    endfunction

    function void restart();
      mode       = MODE_NORMAL;
      space_due  = 1'b0;
      sep_last   = 1'b0;
      colon_seen = 1'b0;
      colon_at   = '0;
      out_cnt    = 0;
    endfunction

    function void report(string what);
      $display("[%0t] MISMATCH: %s", $realtime, what);
      err_cnt++;
    endfunction

    function bit is_lws(logic [7:0] b);
      return b == ChSpace || b == ChTab;
    endfunction

    function void emit(logic [7:0] b);
      out_item_t r;
      r            = '0;
      r.out_byte   = b;
      r.byte_valid = 1'b1;
      pending_out.push_back(r);
      if (out_cnt < max_len - 1) out_cnt++;
    endfunction

    function void note_input(hdr_item_t it);
      out_item_t   d;
      int unsigned n0;
      n0 = pending_out.size();
      if (it.last) begin
        d             = '0;
        d.done_res    = 1'b1;
        d.colon_found = colon_seen;
        d.colon_pos   = colon_seen ? colon_at : '0;
        d.run_last    = 1'b1;
        pending_out.push_back(d);
        restart();
        return;
      end
      case (mode)
        MODE_NORMAL: begin
          if (it.ch == ChColon || it.ch == ChSemi || it.ch == ChComma ||
              it.ch == ChEqual) begin
            space_due = 1'b0;
            if (it.ch == ChColon && !colon_seen) begin
              colon_seen = 1'b1;
              colon_at   = 10'(out_cnt);
            end
            emit(it.ch);
            sep_last = 1'b1;
          end else if (is_lws(it.ch)) begin
            space_due = 1'b1;
          end else if (it.ch == ChLf) begin
            space_due = 1'b0;
            mode      = MODE_LF;
          end else if (it.ch == ChCr) begin
            space_due = 1'b0;
            mode      = MODE_CR;
          end else if (it.ch == ChQuote) begin
            space_due = 1'b0;
            emit(it.ch);
            mode = MODE_QUOTED;
          end else begin
            // separator swallows the white space that follows it
            if (sep_last) sep_last = 1'b0;
            else if (space_due) emit(ChSpace);
            space_due = 1'b0;
            emit(it.ch);
          end
        end
        MODE_QUOTED: begin
          emit(it.ch);
          if (it.ch == ChQuote) mode = MODE_NORMAL;
        end
        MODE_LF, MODE_CRLF: begin
          if (is_lws(it.ch)) begin
            space_due = 1'b1;
            mode      = MODE_NORMAL;
          end else begin
            mode = MODE_STOP;
          end
        end
        MODE_CR: begin
          if (it.ch == ChLf) begin
            mode = MODE_CRLF;
          end else if (is_lws(it.ch)) begin
            space_due = 1'b1;
            mode      = MODE_NORMAL;
          end else begin
            mode = MODE_STOP;
          end
        end
        default: ;
      endcase
      if (pending_out.size() > n0) pending_out[$].run_last = 1'b1;
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      if (pending_out.size() == 0) begin
        report($sformatf("unexpected output item byte=%02h user=%b%b",
                         got.out_byte, got.done_res, got.byte_valid));
        return;
      end
      e = pending_out.pop_front();
      if (got.out_byte !== e.out_byte)
        report($sformatf("out_byte got %02h exp %02h", got.out_byte, e.out_byte));
      if (got.byte_valid !== e.byte_valid)
        report($sformatf("byte_valid got %b exp %b", got.byte_valid, e.byte_valid));
      if (got.done_res !== e.done_res)
        report($sformatf("done_res got %b exp %b", got.done_res, e.done_res));
      if (got.colon_found !== e.colon_found)
        report($sformatf("colon_found got %b exp %b", got.colon_found, e.colon_found));
      if (got.colon_pos !== e.colon_pos)
        report($sformatf("colon_pos got %0d exp %0d", got.colon_pos, e.colon_pos));
      if (got.run_last !== e.run_last)
        report($sformatf("run_last got %b exp %b", got.run_last, e.run_last));
    endfunction
  endclass

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  unfold_scoreboard sb = new(MaxLen);
  hdr_item_t        stim_q[$];
  bit               quiet = 1'b0;
  int unsigned      items_in   = 0;
  int unsigned      results_in = 0;
  int unsigned      headers    = 0;
  int unsigned      idle_cnt   = 0;

  mime_header_unfold_compact_top #(
    .MAX_LEN (MaxLen)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    m_axis_tready <= quiet || ($urandom_range(99) >= IdlePct);
  end

  always @(posedge clk_i) begin
    out_item_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.out_byte    = m_axis_tdata[7:0];
      got.colon_found = m_axis_tdata[8];
      got.colon_pos   = m_axis_tdata[18:9];
      got.byte_valid  = m_axis_tuser[0];
      got.done_res    = m_axis_tuser[1];
      got.run_last    = m_axis_tlast;
      sb.check_result(got);
      results_in++;
    end
  end

  // Stall watchdog: no item moving on either side for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cnt <= 0;
      end else if (idle_cnt >= WdLimit) begin
        $display("Watchdog expired with %0d output items owed", sb.pending_out.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        idle_cnt <= idle_cnt + 1;
      end
    end
  end

  task automatic put(logic [7:0] ch);
    stim_q.push_back('{ch: ch, last: 1'b0});
  endtask

  task automatic put_end();
    stim_q.push_back('{ch: 8'($urandom_range(255)), last: 1'b1});
  endtask

  task automatic put_lws();
    put($urandom_range(1) ? ChSpace : ChTab);
  endtask

  task automatic put_line_end();
    case ($urandom_range(2))
      0: put(ChCr);
      1: put(ChLf);
      default: begin
        put(ChCr);
        put(ChLf);
      end
    endcase
  endtask

  task automatic put_sep();
    case ($urandom_range(3))
      0: put(ChColon);
      1: put(ChSemi);
      2: put(ChComma);
      default: put(ChEqual);
    endcase
  endtask

  // One header: mostly well-formed token streams, some stopped, some noise.
  task automatic gen_header();
    int unsigned kind;
    int unsigned ntok;
    int unsigned r;
    kind = $urandom_range(99);
    if (kind >= 90) begin
      repeat ($urandom_range(12, 1)) put(8'($urandom_range(255)));
      put_end();
      return;
    end
    if ($urandom_range(99) < 70) begin
      repeat ($urandom_range(6, 1)) put(8'($urandom_range(8'h7A, 8'h41)));
      if ($urandom_range(3) == 0) put_lws();
      put(ChColon);
    end
    ntok = $urandom_range(10, 1);
    repeat (ntok) begin
      r = $urandom_range(99);
      if (r < 35) begin
        repeat ($urandom_range(5, 1)) put(8'($urandom_range(126, 33)));
      end else if (r < 50) begin
        repeat ($urandom_range(3, 1)) put_lws();
      end else if (r < 65) begin
        if ($urandom_range(1)) put_lws();
        put_sep();
        if ($urandom_range(1)) put_lws();
      end else if (r < 75) begin
        put(ChQuote);
        repeat ($urandom_range(4)) begin
          do r = $urandom_range(255); while (r == ChQuote);
          put(8'(r));
        end
        if ($urandom_range(9) != 0) put(ChQuote);
      end else if (r < 88) begin
        put_line_end();
        repeat ($urandom_range(2, 1)) put_lws();
      end else begin
        put($urandom_range(3) == 0 ? 8'h00 : 8'($urandom_range(255, 128)));
      end
    end
    if (kind >= 80) begin
      put_line_end();
      do r = $urandom_range(255); while (r == ChSpace || r == ChTab);
      // CR followed by LF is not a stop yet, so force a non-LF after a CR
      if (stim_q.size() > 0 && stim_q[$].ch == ChCr && r == ChLf) r = 8'h41;
      put(8'(r));
      repeat ($urandom_range(4)) put(8'($urandom_range(255)));
    end else if ($urandom_range(9) == 0) begin
      put_lws();
    end
    put_end();
  endtask

  // Leaves tvalid up after the last accepted item; the caller drops it.
  task automatic drive_queued();
    hdr_item_t it;
    while (stim_q.size() > 0) begin
      it    = stim_q.pop_front();
      quiet = (items_in >= QuietLo) && (items_in < QuietHi);
      while (!quiet && $urandom_range(99) < IdlePct) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= it.ch;
      s_axis_tlast  <= it.last;
      @(posedge clk_i);
      while (!s_axis_tready) @(posedge clk_i);
      sb.note_input(it);
      items_in++;
      if (it.last) headers++;
    end
    quiet = 1'b0;
  endtask

  initial begin
    int unsigned rand_start;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // space before a character, separator spacing, quotes, fold, stop
    put(8'h61); put(ChSpace); put(8'h62); put(ChColon); put(ChSpace);
    put(ChQuote); put(ChSpace); put(ChQuote); put(ChTab); put(8'h63);
    put(ChCr); put(ChLf); put(ChTab); put(8'h00); put(ChLf); put(8'h78);
    put(8'h79); put_end();
    // end with a line end open, then with a quote open
    put(8'hFF); put(ChCr); put(ChSpace); put(ChSemi); put(ChEqual);
    put(ChComma); put(ChLf); put_end();
    put(ChQuote); put(8'h71); put_end();
    drive_queued();

    rand_start = items_in;
    while (items_in - rand_start < RandGoal) begin
      // one header long enough to saturate the output counter
      if (headers == 8) begin
        repeat (MaxLen + 4) put(8'h6B);
        put(ChColon);
        put(8'h7A);
        put_end();
      end else begin
        gen_header();
      end
      drive_queued();
    end
    s_axis_tvalid <= 1'b0;

    while (sb.pending_out.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.pending_out.size() > 0)
      sb.report($sformatf("%0d output items never arrived", sb.pending_out.size()));

    $display("Covered %0d headers, %0d input items, %0d output items checked",
             headers, items_in, results_in);
    $display("Included folds, stops, quoted text, separators and counter saturation");
    if (sb.err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
